[rtl/core/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/fsp_pkg.sv]
package fsp_pkg;

  localparam int VALUE_SLOTS = 4;
  localparam int NUM_RESULTS = 4;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 5;
  localparam int SLOT_W      = 2;
  localparam int STATUS_W    = 2;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [STATUS_W-1:0] status_t;

  // frame positions
  localparam pos_t CMD_POS         = 5'd1;
  localparam pos_t FIRST_VALUE_POS = 5'd3;
  localparam pos_t VOLT_LAST_POS   = 5'd19;
  localparam pos_t ANGLE_LAST_POS  = 5'd16;
  localparam pos_t VOLT_VALUE_END  = 5'd19;
  localparam pos_t ANGLE_VALUE_END = 5'd15;

  localparam logic KIND_VOLT  = 1'b0;
  localparam logic KIND_ANGLE = 1'b1;

  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_CMD_MISMATCH = 2'd1;
  localparam status_t ST_SUM_MISMATCH = 2'd2;

  localparam logic [0:0] CFG_EXPECTED_COMMAND = 1'b0;
  localparam logic [0:0] CFG_FRAME_KIND       = 1'b1;

  localparam byte_t CMD_RESET  = 8'h04;
  localparam logic  KIND_RESET = KIND_ANGLE;

  localparam slot_t LAST_SLOT = slot_t'(NUM_RESULTS - 1);

  typedef struct packed {
    logic  valid;
    byte_t rx_byte;
    logic  frame_start;
  } in_item_t;

  typedef struct packed {
    byte_t expected_command;
    logic  frame_kind;
  } cfg_t;

  typedef struct packed {
    logic                        load;
    status_t                     status;
    logic [NUM_RESULTS-1:0][WORD_W-1:0] words;
  } burst_load_t;

endpackage

[rtl/core/sun_sensor_response_frame_parser.sv]
// channel   dir  beat                                    handshake
// in_       in   rx_byte, frame_start                    in_valid / in_stall
// out_      out  word_value, slot, status, last          out_valid / out_stall
// cfg_      in   index 0 expected_command, 1 frame_kind  cfg_we
//
// one byte per cycle when not stalled; a byte is registered, then updates the frame state
// the checksum byte loads four results into the output register set, sent one per unstalled cycle
// a checksum byte waits in the input register only while the previous four are still going out
// synchronous active-low reset; no clearing pass, the block takes bytes right after reset
module sun_sensor_response_frame_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fsp_pkg::byte_t      in_rx_byte,
  input  logic                in_frame_start,
  output logic                out_valid,
  input  logic                out_stall,
  output fsp_pkg::word_t      out_word_value,
  output fsp_pkg::slot_t      out_slot,
  output fsp_pkg::status_t    out_status,
  output logic                out_last,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  fsp_pkg::byte_t      cfg_wdata
);
  import fsp_pkg::*;

  cfg_t        cfg_r;
  in_item_t    item;
  logic        take;
  logic        burst_free;
  burst_load_t burst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_command <= CMD_RESET;
      cfg_r.frame_kind       <= KIND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_COMMAND: cfg_r.expected_command <= cfg_wdata;
        CFG_FRAME_KIND:       cfg_r.frame_kind       <= cfg_wdata[0];
        default:              cfg_r                  <= cfg_r;
      endcase
    end
  end

  fsp_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_rx_byte     (in_rx_byte),
    .in_frame_start (in_frame_start),
    .take           (take),
    .in_stall       (in_stall),
    .item           (item)
  );

  fsp_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .cfg        (cfg_r),
    .burst_free (burst_free),
    .take       (take),
    .burst      (burst)
  );

  fsp_burst u_burst (
    .clk            (clk),
    .rst_n          (rst_n),
    .burst          (burst),
    .burst_free     (burst_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_value (out_word_value),
    .out_slot       (out_slot),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

[rtl/core/fsp_in_reg.sv]
module fsp_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  fsp_pkg::byte_t  in_rx_byte,
  input  logic            in_frame_start,
  input  logic            take,
  output logic            in_stall,
  output fsp_pkg::in_item_t item
);
  import fsp_pkg::*;

  in_item_t item_r;

  assign in_stall = item_r.valid && !take;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (!in_stall) begin
      item_r.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.rx_byte     <= in_rx_byte;
      item_r.frame_start <= in_frame_start;
    end
  end

endmodule

[rtl/core/fsp_frame.sv]
module fsp_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsp_pkg::in_item_t    item,
  input  fsp_pkg::cfg_t        cfg,
  input  logic                 burst_free,
  output logic                 take,
  output fsp_pkg::burst_load_t burst
);
  import fsp_pkg::*;

  pos_t  pos_r;
  byte_t sum_r;
  logic  cmd_ok_r;
  byte_t err_r;
  logic [VALUE_SLOTS-1:0][WORD_W-1:0] words_r;

  logic    angle;
  pos_t    last_pos;
  pos_t    value_end;
  logic    active;
  logic    ends;
  logic    store;
  logic    err_wr;
  pos_t    off;
  byte_t   sum_add;
  status_t status;

  always_comb begin
    angle     = cfg.frame_kind == KIND_ANGLE;
    last_pos  = angle ? ANGLE_LAST_POS : VOLT_LAST_POS;
    value_end = angle ? ANGLE_VALUE_END : VOLT_VALUE_END;
    active    = item.valid && !item.frame_start && (pos_r != '0);
    ends      = active && (pos_r >= last_pos);
    take      = item.valid && (!ends || burst_free);
    off       = pos_r - FIRST_VALUE_POS;
    store     = active && !ends && (pos_r >= FIRST_VALUE_POS) && (pos_r < value_end);
    err_wr    = active && !ends && angle && (pos_r == value_end);
    sum_add   = sum_r + item.rx_byte;
    priority if (!cmd_ok_r) begin
      status = ST_CMD_MISMATCH;
    end else if (sum_r != item.rx_byte) begin
      status = ST_SUM_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    burst.load   = take && ends;
    burst.status = status;
    for (int s = 0; s < NUM_RESULTS; s++) begin
      if (status != ST_OK) begin
        burst.words[s] = '0;
      end else if (angle && (s == NUM_RESULTS - 1)) begin
        burst.words[s] = word_t'(err_r);
      end else if (s < VALUE_SLOTS) begin
        burst.words[s] = words_r[s];
      end else begin
        burst.words[s] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      cmd_ok_r <= 1'b0;
      err_r    <= '0;
    end else if (take) begin
      priority if (item.frame_start) begin
        pos_r    <= CMD_POS;
        sum_r    <= '0;
        cmd_ok_r <= 1'b0;
      end else if (pos_r == '0) begin
        pos_r <= '0;
      end else if (ends) begin
        pos_r    <= '0;
        sum_r    <= '0;
        cmd_ok_r <= 1'b0;
      end else begin
        if (pos_r == CMD_POS) begin
          cmd_ok_r <= item.rx_byte == cfg.expected_command;
          sum_r    <= item.rx_byte;
        end else begin
          sum_r <= sum_add;
        end
        if (err_wr) begin
          err_r <= item.rx_byte;
        end
        pos_r <= pos_r + 5'd1;
      end
    end
  end

  // value bytes, little-endian into their word
  always_ff @(posedge clk) begin
    if (take && store) begin
      for (int k = 0; k < VALUE_SLOTS; k++) begin
        for (int l = 0; l < WORD_W / BYTE_W; l++) begin
          if ((off[POS_W-1:2] == 3'(k)) && (off[1:0] == 2'(l))) begin
            words_r[k][l*BYTE_W +: BYTE_W] <= item.rx_byte;
          end
        end
      end
    end
  end

endmodule

[rtl/core/fsp_burst.sv]
module fsp_burst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsp_pkg::burst_load_t burst,
  output logic                 burst_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fsp_pkg::word_t       out_word_value,
  output fsp_pkg::slot_t       out_slot,
  output fsp_pkg::status_t     out_status,
  output logic                 out_last
);
  import fsp_pkg::*;

  logic    busy_r;
  slot_t   idx_r;
  status_t status_r;
  logic [NUM_RESULTS-1:0][WORD_W-1:0] words_r;

  assign out_valid      = busy_r;
  assign out_slot       = idx_r;
  assign out_status     = status_r;
  assign out_word_value = words_r[idx_r];
  assign out_last       = idx_r == LAST_SLOT;
  assign burst_free     = !busy_r || (!out_stall && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (burst.load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && !out_stall) begin
      if (out_last) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      words_r  <= burst.words;
      status_r <= burst.status;
    end
  end

endmodule

[rtl/core/fsp_checker.sv]
`include "assert_macros.svh"

module fsp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input fsp_pkg::word_t      out_word_value,
  input fsp_pkg::slot_t      out_slot,
  input fsp_pkg::status_t    out_status,
  input logic                out_last
);
  import fsp_pkg::*;

  `ASSERT_SAME(a_last_on_final_slot, clk, rst_n, out_valid,
               out_last == (out_slot == LAST_SLOT))
  `ASSERT_SAME(a_zero_value_on_error, clk, rst_n, out_valid && (out_status != ST_OK),
               out_word_value == '0)
  `ASSERT_NEXT(a_slots_in_order, clk, rst_n, out_valid && !out_stall && !out_last,
               out_valid && (out_slot == $past(out_slot) + 2'd1) && $stable(out_status))
  `ASSERT_NEXT(a_stalled_result_holds, clk, rst_n, out_valid && out_stall,
               out_valid && $stable(out_word_value) && $stable(out_slot) && $stable(out_status))

endmodule

bind sun_sensor_response_frame_parser fsp_checker u_fsp_checker (.*);
